/* rtl/core/rgbbm_pkg.sv */
package rgbbm_pkg;

    // Widths of the pixel word, one output channel and the mask analysis.
    localparam int PIX_W       = 16;
    localparam int CH_W        = 8;
    localparam int START_W     = 4;
    localparam int LEN_W       = 4;
    localparam int MAX_RUN     = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int OUT_W       = 3 * CH_W;

    // Reciprocal multiplier: q = (x * m) >> RECIP_SHIFT with m = ceil(2^24 / d).
    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 24;
    localparam int PROD_W      = PIX_W + RECIP_W;

    localparam logic [CH_W-1:0]  FULL_SCALE = 8'd255;

    localparam logic [PIX_W-1:0] RED_MASK_RST   = 16'hF800;
    localparam logic [PIX_W-1:0] GREEN_MASK_RST = 16'h07E0;
    localparam logic [PIX_W-1:0] BLUE_MASK_RST  = 16'h001F;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RED_MASK   = 2'd0,
        REG_GREEN_MASK = 2'd1,
        REG_BLUE_MASK  = 2'd2
    } cfg_index_t;

    // Load enables of the three pipeline stages, shared by all channels.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

    // Scaled reciprocal of the divisor 2^len - 1 (divisor 1 for a run of 0 or 1).
    // The rounding error stays below the divisor, so the quotient is exact
    // for every dividend below 2^16.
    function automatic logic [RECIP_W-1:0] recip_of_len(input logic [LEN_W-1:0] len);
        logic [RECIP_W-1:0] m;
        case (len)
            4'd0:    m = 25'd16777216;
            4'd1:    m = 25'd16777216;
            4'd2:    m = 25'd5592406;
            4'd3:    m = 25'd2396746;
            4'd4:    m = 25'd1118482;
            4'd5:    m = 25'd541201;
            4'd6:    m = 25'd266306;
            4'd7:    m = 25'd132105;
            4'd8:    m = 25'd65794;
            default: m = 25'd65794;
        endcase
        return m;
    endfunction

endpackage

/* rtl/core/rgb16_bitmask_to_rgb888_unit.sv */
// Expands 16-bit packed pixels into 8-bit red, green and blue.
// Input stream s_axis carries one packed pixel per item; output stream m_axis
// carries one 24-bit colour item per input item, in the same order.
// Three channel masks are written through the plain write port (cfg_we,
// cfg_index, cfg_wdata); a write to index three is ignored. Masks should be
// changed only while no item is in flight.
// The pipeline has three stages from acceptance to m_axis_tvalid: mask
// analysis, run length and field alignment, and the reciprocal multiply with
// saturation that feeds the output register.
// Throughput is one item per clock whenever the receiver takes every item.
// When the receiver stalls, the output register holds its item and each stage
// fills in turn; s_axis_tready falls only once all three stages are full, so
// no item is lost or repeated.
// Reset (rst_n low, asynchronous) empties the pipeline and restores the masks
// to the 5-6-5 layout: red 0xF800, green 0x07E0, blue 0x001F.
module rgb16_bitmask_to_rgb888_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [rgbbm_pkg::PIX_W-1:0]     s_axis_tdata,   // [15:0] packed_pixel
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [rgbbm_pkg::OUT_W-1:0]     m_axis_tdata,   // [7:0] red_out,
                                                            // [15:8] green_out,
                                                            // [23:16] blue_out
    input  logic                            cfg_we,
    input  logic [rgbbm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rgbbm_pkg::PIX_W-1:0]     cfg_wdata
);
    import rgbbm_pkg::*;

    // Configuration registers.
    logic [PIX_W-1:0] red_mask_reg;
    logic [PIX_W-1:0] green_mask_reg;
    logic [PIX_W-1:0] blue_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_mask_reg   <= RED_MASK_RST;
            green_mask_reg <= GREEN_MASK_RST;
            blue_mask_reg  <= BLUE_MASK_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RED_MASK:   red_mask_reg   <= cfg_wdata;
                REG_GREEN_MASK: green_mask_reg <= cfg_wdata;
                REG_BLUE_MASK:  blue_mask_reg  <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // Pipeline control. A stage may load when it is empty or when the stage
    // after it is moving on in the same cycle.
    logic      v1_reg, v2_reg, v3_reg;
    logic      v1_next, v2_next, v3_next;
    logic      ready1, ready2, ready3;
    stage_en_t en;

    always_comb
    begin
        ready3  = !v3_reg || m_axis_tready;
        ready2  = !v2_reg || ready3;
        ready1  = !v1_reg || ready2;
        v1_next = ready1 ? s_axis_tvalid : v1_reg;
        v2_next = ready2 ? v1_reg : v2_reg;
        v3_next = ready3 ? v2_reg : v3_reg;
        en.s1   = ready1 && s_axis_tvalid;
        en.s2   = ready2 && v1_reg;
        en.s3   = ready3 && v2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    assign s_axis_tready = ready1;
    assign m_axis_tvalid = v3_reg;

    // One datapath per colour channel, all driven by the same stage enables.
    logic [CH_W-1:0] red_val;
    logic [CH_W-1:0] green_val;
    logic [CH_W-1:0] blue_val;

    rgbbm_chan u_red (
        .clk   (clk),
        .en    (en),
        .pixel (s_axis_tdata),
        .mask  (red_mask_reg),
        .value (red_val)
    );

    rgbbm_chan u_green (
        .clk   (clk),
        .en    (en),
        .pixel (s_axis_tdata),
        .mask  (green_mask_reg),
        .value (green_val)
    );

    rgbbm_chan u_blue (
        .clk   (clk),
        .en    (en),
        .pixel (s_axis_tdata),
        .mask  (blue_mask_reg),
        .value (blue_val)
    );

    assign m_axis_tdata = {blue_val, green_val, red_val};

`ifndef SYNTH
    // An empty first stage always takes an item.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg |-> s_axis_tready)
        else $error("input not ready although the first stage is empty");

    // With every stage full and the receiver stalled, no item may enter.
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("item accepted into a full, stalled pipeline");

    // An accepted item occupies the first stage in the next cycle.
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> v1_reg)
        else $error("accepted item did not reach the first stage");

    // An item in the middle stage is never dropped while the output stalls.
    a_mid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && v3_reg && !m_axis_tready) |=> (v2_reg && v3_reg))
        else $error("item lost from the middle stage during a stall");
`endif

endmodule

/* rtl/core/rgbbm_chan.sv */
module rgbbm_chan (
    input  logic                        clk,
    input  rgbbm_pkg::stage_en_t        en,
    input  logic [rgbbm_pkg::PIX_W-1:0] pixel,
    input  logic [rgbbm_pkg::PIX_W-1:0] mask,
    output logic [rgbbm_pkg::CH_W-1:0]  value
);
    import rgbbm_pkg::*;

    // Stage 1: mask the pixel and find the lowest set bit of the mask.
    logic [PIX_W-1:0]   masked_reg;
    logic [PIX_W-1:0]   mask_reg;
    logic [START_W-1:0] start_reg;
    logic [START_W-1:0] start_next;

    always_comb
    begin
        start_next = '0;
        for (int i = PIX_W - 1; i >= 0; i--)
        begin
            if (mask[i])
            begin
                start_next = START_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            masked_reg <= pixel & mask;
            mask_reg   <= mask;
            start_reg  <= start_next;
        end
    end

    // Stage 2: align the field, measure the run of ones and flag overflow.
    logic [PIX_W-1:0] field_full;
    logic [PIX_W-1:0] run_mask;
    logic [LEN_W-1:0] len_next;
    logic             sat_next;
    logic [CH_W-1:0]  field_reg;
    logic [LEN_W-1:0] len_reg;
    logic             sat_reg;

    always_comb
    begin
        logic run;
        field_full = masked_reg >> start_reg;
        run_mask   = mask_reg >> start_reg;
        run        = 1'b1;
        len_next   = '0;
        for (int i = 0; i < MAX_RUN; i++)
        begin
            if (run && run_mask[i])
            begin
                len_next = len_next + 1'b1;
            end
            else
            begin
                run = 1'b0;
            end
        end
        // A field above 2^len - 1 gives a quotient of 255 or more.
        sat_next = (field_full >> len_next) != '0;
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            field_reg <= field_full[CH_W-1:0];
            len_reg   <= len_next;
            sat_reg   <= sat_next;
        end
    end

    // Stage 3: 255 * field divided by 2^len - 1 through the reciprocal.
    logic [PIX_W-1:0]  scaled;
    logic [PROD_W-1:0] prod;
    logic [CH_W-1:0]   value_next;
    logic [CH_W-1:0]   value_reg;

    always_comb
    begin
        scaled     = {field_reg, CH_W'(0)} - {CH_W'(0), field_reg};
        prod       = PROD_W'(scaled) * PROD_W'(recip_of_len(len_reg));
        value_next = sat_reg ? FULL_SCALE : prod[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule
